>>> rtl/core/mlpfi_pkg.sv
// shared types and constants for the two-layer perceptron inference block
`default_nettype none
package mlpfi_pkg;

   // input beat
   typedef struct packed {
      logic [1:0]         kind;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [15:0] value;
      logic               last;
   } mlpfi_req_type;

   // result beat
   typedef struct packed {
      logic [3:0]  node_index;
      logic [12:0] activation;
      logic        final_res;
   } mlpfi_rsp_type;

   // classified operation handed from the front to the back
   typedef struct packed {
      logic [1:0]         op;
      logic               start;
      logic [5:0]         row;
      logic [5:0]         col;
      logic signed [15:0] value;
   } mlpfi_op_type;

   localparam logic [1:0] KIND_WR_HID  = 2'd0;
   localparam logic [1:0] KIND_WR_OUT  = 2'd1;
   localparam logic [1:0] KIND_FEATURE = 2'd2;

   localparam logic [1:0] OP_WR_HID = 2'd0;
   localparam logic [1:0] OP_WR_OUT = 2'd1;
   localparam logic [1:0] OP_FEAT   = 2'd2;
   localparam logic [1:0] OP_RUN    = 2'd3;

   localparam logic [1:0] CSR_INPUTS  = 2'd0;
   localparam logic [1:0] CSR_HIDDEN  = 2'd1;
   localparam logic [1:0] CSR_OUTPUTS = 2'd2;

   localparam logic [6:0] RESET_INPUTS  = 7'd12;
   localparam logic [6:0] RESET_HIDDEN  = 7'd9;
   localparam logic [4:0] RESET_OUTPUTS = 5'd4;

   localparam int RESULT_LIMIT = 16;
   localparam int ACC_W        = 40;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QP_W         = 2;

   localparam logic [30:0] ONE_Q30 = 31'd1073741824;

   // exp(-2^k/4096) in Q0.30
   localparam logic [29:0] EXP_NEG_BIT [15] = '{
      30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
      30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
      30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
      30'd395007542,  30'd145315154,  30'd19666268
   };

endpackage
`default_nettype wire

>>> rtl/core/mlpfi_front.sv
// input classification and operation queue
`default_nettype none
module mlpfi_front import mlpfi_pkg::*; #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_HIDDEN  = 64,
   parameter int MAX_OUTPUTS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire mlpfi_req_type req_data,
   output logic               q_valid,
   output mlpfi_op_type       q_op,
   input  wire logic          q_pop
);

   mlpfi_op_type       entry_ff [QUEUE_DEPTH];
   logic [QP_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QP_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QP_W:0]      count_ff, count_in;
   logic               keep;
   logic               push;
   mlpfi_op_type       op;

   always_comb begin
      keep     = 1'b0;
      op.op    = OP_RUN;
      op.start = 1'b0;
      op.row   = req_data.row;
      op.col   = req_data.col;
      op.value = req_data.value;
      case (req_data.kind)
         KIND_WR_HID: begin
            op.op = OP_WR_HID;
            keep  = (int'(req_data.row) < MAX_HIDDEN) && (int'(req_data.col) < MAX_INPUTS);
         end
         KIND_WR_OUT: begin
            op.op = OP_WR_OUT;
            keep  = (int'(req_data.row) < MAX_OUTPUTS) && (int'(req_data.col) < MAX_HIDDEN);
         end
         KIND_FEATURE: begin
            // a feature beyond the buffer is dropped but last still runs
            op.start = req_data.last;
            if (int'(req_data.col) < MAX_INPUTS) begin
               op.op = OP_FEAT;
               keep  = 1'b1;
            end else begin
               op.op = OP_RUN;
               keep  = req_data.last;
            end
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = (count_ff == (QP_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign q_valid   = (count_ff != '0);
   assign q_op      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= op;
      end
   end

endmodule
`default_nettype wire

>>> rtl/core/mlpfi_sigmoid.sv
// multi-cycle sigmoid: exp by bit products, then restoring division
`default_nettype none
module mlpfi_sigmoid import mlpfi_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               sig_start,
   input  wire logic signed [15:0] sig_x,
   output logic                    sig_done,
   output logic [12:0]             sig_y
);

   localparam logic [1:0] SG_IDLE = 2'd0;
   localparam logic [1:0] SG_EXP  = 2'd1;
   localparam logic [1:0] SG_PREP = 2'd2;
   localparam logic [1:0] SG_DIV  = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic        pos_ff, pos_in;
   logic [14:0] t_ff, t_in;
   logic [3:0]  k_ff, k_in;
   logic [30:0] e_ff, e_in;
   logic [31:0] den_ff, den_in;
   logic [31:0] rem_ff, rem_in;
   logic [12:0] dlow_ff, dlow_in;
   logic [12:0] q_ff, q_in;
   logic        done_ff, done_in;

   logic [60:0] prod;
   logic [60:0] rnd;
   logic [31:0] den;
   logic [30:0] num;
   logic [42:0] dvd;
   logic [32:0] rem_sh;
   logic [32:0] diff;
   logic        ge;

   assign prod   = e_ff * EXP_NEG_BIT[k_ff];
   assign rnd    = prod + 61'd536870912;
   assign den    = 32'(ONE_Q30) + 32'(e_ff);
   assign num    = pos_ff ? ONE_Q30 : e_ff;
   assign dvd    = (43'(num) << 12) + 43'(den >> 1);
   assign rem_sh = {rem_ff, dlow_ff[12]};
   assign diff   = rem_sh - {1'b0, den_ff};
   assign ge     = (rem_sh >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      t_in     = t_ff;
      k_in     = k_ff;
      e_in     = e_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      dlow_in  = dlow_ff;
      q_in     = q_ff;
      done_in  = 1'b0;
      case (state_ff)
         SG_IDLE: begin
            if (sig_start) begin
               // table entry center magnitude: index bits over a half step
               pos_in   = !sig_x[15];
               t_in     = {(sig_x[15] ? ~sig_x[14:6] : sig_x[14:6]), 6'b100000};
               e_in     = ONE_Q30;
               k_in     = '0;
               state_in = SG_EXP;
            end
         end
         SG_EXP: begin
            if (t_ff[k_ff]) begin
               e_in = rnd[60:30];
            end
            if (k_ff == 4'd14) begin
               state_in = SG_PREP;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         SG_PREP: begin
            den_in   = den;
            rem_in   = 32'(dvd[42:13]);
            dlow_in  = dvd[12:0];
            q_in     = '0;
            k_in     = '0;
            state_in = SG_DIV;
         end
         SG_DIV: begin
            rem_in  = ge ? diff[31:0] : rem_sh[31:0];
            q_in    = {q_ff[11:0], ge};
            dlow_in = {dlow_ff[11:0], 1'b0};
            if (k_ff == 4'd12) begin
               done_in  = 1'b1;
               state_in = SG_IDLE;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         default: begin
            state_in = SG_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SG_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      t_ff    <= t_in;
      k_ff    <= k_in;
      e_ff    <= e_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      dlow_ff <= dlow_in;
      q_ff    <= q_in;
   end

   assign sig_done = done_ff;
   assign sig_y    = q_ff;

endmodule
`default_nettype wire

>>> rtl/core/mlpfi_back.sv
// weight stores, shared multiply-accumulate and layer sequencer
`default_nettype none
module mlpfi_back import mlpfi_pkg::*; #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_HIDDEN  = 64,
   parameter int MAX_OUTPUTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         csr_wr_en,
   input  wire logic [1:0]   csr_index,
   input  wire logic [6:0]   csr_wdata,
   input  wire logic         q_valid,
   input  wire mlpfi_op_type q_op,
   output logic              q_pop,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output mlpfi_rsp_type     rsp_data
);

   localparam int IN_AW   = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
   localparam int HID_AW  = (MAX_HIDDEN > 1) ? $clog2(MAX_HIDDEN) : 1;
   localparam int HW_AW   = (MAX_HIDDEN * MAX_INPUTS > 1) ?
                            $clog2(MAX_HIDDEN * MAX_INPUTS) : 1;
   localparam int OW_AW   = (MAX_OUTPUTS * MAX_HIDDEN > 1) ?
                            $clog2(MAX_OUTPUTS * MAX_HIDDEN) : 1;
   localparam int B_W     = (HW_AW > OW_AW) ? HW_AW : OW_AW;
   localparam int K_W     = (IN_AW > HID_AW) ? IN_AW : HID_AW;
   localparam int N_W     = (HID_AW > 4) ? HID_AW : 4;
   localparam int OUT_LIM = (MAX_OUTPUTS < RESULT_LIMIT) ? MAX_OUTPUTS : RESULT_LIMIT;
   localparam int SH_W    = ACC_W - 12;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_ISSUE    = 3'd1;
   localparam logic [2:0] ST_DRAIN    = 3'd2;
   localparam logic [2:0] ST_SIG_GO   = 3'd3;
   localparam logic [2:0] ST_SIG_WAIT = 3'd4;
   localparam logic [2:0] ST_EMIT     = 3'd5;

   function automatic int clamp_cnt(int v, int hi);
      int r;
      r = v;
      if (v < 1) r = 1;
      else if (v > hi) r = hi;
      return r;
   endfunction

   // configuration
   logic [6:0] cfg_ni_ff, cfg_nh_ff;
   logic [4:0] cfg_no_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ni_ff <= RESET_INPUTS;
         cfg_nh_ff <= RESET_HIDDEN;
         cfg_no_ff <= RESET_OUTPUTS;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_INPUTS:  cfg_ni_ff <= csr_wdata;
            CSR_HIDDEN:  cfg_nh_ff <= csr_wdata;
            CSR_OUTPUTS: cfg_no_ff <= csr_wdata[4:0];
            default: begin
            end
         endcase
      end
   end

   // memories
   logic signed [15:0] hw_mem   [MAX_HIDDEN * MAX_INPUTS];
   logic signed [15:0] ow_mem   [MAX_OUTPUTS * MAX_HIDDEN];
   logic signed [15:0] feat_mem [MAX_INPUTS];
   logic [12:0]        hact_mem [MAX_HIDDEN];

   logic signed [15:0] hw_rd_ff, ow_rd_ff, feat_rd_ff;
   logic [12:0]        hact_rd_ff;

   // sequencer state
   logic [2:0]        state_ff, state_in;
   logic              layer_ff, layer_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [N_W-1:0]    node_ff, node_in;
   logic [B_W-1:0]    base_ff, base_in;
   logic [IN_AW-1:0]  ni_last_ff, ni_last_in;
   logic [HID_AW-1:0] nh_last_ff, nh_last_in;
   logic [3:0]        no_last_ff, no_last_in;

   // mac pipeline
   logic                    v1_ff, f1_ff, l1_ff;
   logic                    v2_ff, f2_ff, l2_ff;
   logic signed [32:0]      prod_ff;
   logic signed [ACC_W-1:0] acc_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   mlpfi_rsp_type     rsp_data_ff;

   logic              issue, first, lastk, hact_we, load, final_flag;
   logic [K_W-1:0]    lastk_val;
   logic [B_W-1:0]    raddr;
   logic              sig_start, sig_done;
   logic [12:0]       sig_y;
   logic signed [15:0] sig_x;
   logic signed [15:0] w_op;
   logic signed [16:0] x_op;
   logic signed [32:0] prod_in;
   logic signed [SH_W-1:0] sh;

   assign raddr     = base_ff + B_W'(k_ff);
   assign lastk_val = layer_ff ? K_W'(nh_last_ff) : K_W'(ni_last_ff);

   always_comb begin
      state_in   = state_ff;
      layer_in   = layer_ff;
      k_in       = k_ff;
      node_in    = node_ff;
      base_in    = base_ff;
      ni_last_in = ni_last_ff;
      nh_last_in = nh_last_ff;
      no_last_in = no_last_ff;
      issue      = 1'b0;
      first      = 1'b0;
      lastk      = 1'b0;
      q_pop      = 1'b0;
      sig_start  = 1'b0;
      hact_we    = 1'b0;
      load       = 1'b0;
      final_flag = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_op.start) begin
                  ni_last_in = IN_AW'(clamp_cnt(int'(cfg_ni_ff), MAX_INPUTS) - 1);
                  nh_last_in = HID_AW'(clamp_cnt(int'(cfg_nh_ff), MAX_HIDDEN) - 1);
                  no_last_in = 4'(clamp_cnt(int'(cfg_no_ff), OUT_LIM) - 1);
                  layer_in   = 1'b0;
                  node_in    = '0;
                  base_in    = '0;
                  k_in       = '0;
                  state_in   = ST_ISSUE;
               end
            end
         end
         ST_ISSUE: begin
            issue = 1'b1;
            first = (k_ff == '0);
            lastk = (k_ff == lastk_val);
            if (lastk) begin
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (v2_ff && l2_ff) begin
               state_in = ST_SIG_GO;
            end
         end
         ST_SIG_GO: begin
            sig_start = 1'b1;
            state_in  = ST_SIG_WAIT;
         end
         ST_SIG_WAIT: begin
            if (sig_done) begin
               k_in = '0;
               if (!layer_ff) begin
                  hact_we = 1'b1;
                  if (node_ff == N_W'(nh_last_ff)) begin
                     layer_in = 1'b1;
                     node_in  = '0;
                     base_in  = '0;
                  end else begin
                     node_in = node_ff + 1'b1;
                     base_in = base_ff + B_W'(MAX_INPUTS);
                  end
                  state_in = ST_ISSUE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load       = 1'b1;
               final_flag = (node_ff == N_W'(no_last_ff));
               if (final_flag) begin
                  state_in = ST_IDLE;
               end else begin
                  node_in  = node_ff + 1'b1;
                  base_in  = base_ff + B_W'(MAX_HIDDEN);
                  state_in = ST_ISSUE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      layer_ff   <= layer_in;
      k_ff       <= k_in;
      node_ff    <= node_in;
      base_ff    <= base_in;
      ni_last_ff <= ni_last_in;
      nh_last_ff <= nh_last_in;
      no_last_ff <= no_last_in;
      f1_ff      <= first;
      l1_ff      <= lastk;
      f2_ff      <= f1_ff;
      l2_ff      <= l1_ff;
   end

   // store writes from the queue, reads for the mac
   always_ff @(posedge clock) begin
      if (q_pop && q_op.op == OP_WR_HID) begin
         hw_mem[HW_AW'(int'(q_op.row) * MAX_INPUTS + int'(q_op.col))] <= q_op.value;
      end
      hw_rd_ff <= hw_mem[raddr[HW_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_op.op == OP_WR_OUT) begin
         ow_mem[OW_AW'(int'(q_op.row) * MAX_HIDDEN + int'(q_op.col))] <= q_op.value;
      end
      ow_rd_ff <= ow_mem[raddr[OW_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_op.op == OP_FEAT) begin
         feat_mem[IN_AW'(q_op.col)] <= q_op.value;
      end
      feat_rd_ff <= feat_mem[k_ff[IN_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (hact_we) begin
         hact_mem[node_ff[HID_AW-1:0]] <= sig_y;
      end
      hact_rd_ff <= hact_mem[k_ff[HID_AW-1:0]];
   end

   // multiply, then accumulate
   assign w_op    = layer_ff ? ow_rd_ff : hw_rd_ff;
   assign x_op    = layer_ff ? $signed({4'b0000, hact_rd_ff}) : 17'(feat_rd_ff);
   assign prod_in = w_op * x_op;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (v2_ff) begin
         acc_ff <= (f2_ff ? '0 : acc_ff) + ACC_W'(prod_ff);
      end
   end

   // floor shift to q3.12, then saturate
   always_comb begin
      sh = acc_ff[ACC_W-1:12];
      if (sh > SH_W'(32767)) begin
         sig_x = 16'sh7fff;
      end else if (sh < -SH_W'(32768)) begin
         sig_x = -16'sh8000;
      end else begin
         sig_x = sh[15:0];
      end
   end

   mlpfi_sigmoid u_sigmoid (
      .clock     (clock),
      .reset     (reset),
      .sig_start (sig_start),
      .sig_x     (sig_x),
      .sig_done  (sig_done),
      .sig_y     (sig_y)
   );

   // result register
   assign rsp_valid_in = load ? 1'b1 : (rsp_stall ? rsp_valid_ff : 1'b0);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff.node_index <= node_ff[3:0];
         rsp_data_ff.activation <= sig_y;
         rsp_data_ff.final_res  <= final_flag;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sig_done |-> state_ff == ST_SIG_WAIT)
      else $error("sigmoid finished outside its wait state");

   a_last_in_drain: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && l2_ff) |-> state_ff == ST_DRAIN)
      else $error("last product accumulated outside drain");

   a_final_to_idle: assert property (@(posedge clock) disable iff (reset)
      (load && final_flag) |=> state_ff == ST_IDLE)
      else $error("sequencer not idle after final result");

endmodule
`default_nettype wire

>>> rtl/core/mlp_forward_inference.sv
// top level of the two-layer perceptron inference block
// Usage:
//   req channel: weight writes (kind 0/1), feature beats (kind 2); a feature
//   beat with last set starts one forward pass. rsp channel: one beat per
//   output node in node order, final_res set on the last one.
//   csr port: plain writes of the three node counts, made by the user only
//   while idle; the block itself does not enforce this.
// Sequencing:
//   the sequencer pops a weight or plain feature beat whenever it is idle;
//   the input queue holds 4 beats and stalls only when full. a forward pass
//   is paced by the single shared multiply-accumulate (one weight per cycle,
//   then a drain) and the serial sigmoid unit.
// Reset: synchronous; counts go to 12/9/4, queue and result register empty,
//   stores are undefined until written.
// Stall: a stalled result beat is held; the pass waits for the result
//   register and the queue keeps accepting input until it is full.
`default_nettype none
module mlp_forward_inference import mlpfi_pkg::*; #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_HIDDEN  = 64,
   parameter int MAX_OUTPUTS = 16
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire mlpfi_req_type req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output mlpfi_rsp_type      rsp_data,
   input  wire logic          csr_wr_en,
   input  wire logic [1:0]    csr_index,
   input  wire logic [6:0]    csr_wdata
);

   logic         q_valid;
   logic         q_pop;
   mlpfi_op_type q_op;

   mlpfi_front #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_HIDDEN  (MAX_HIDDEN),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .q_pop     (q_pop)
   );

   mlpfi_back #(
      .MAX_INPUTS  (MAX_INPUTS),
      .MAX_HIDDEN  (MAX_HIDDEN),
      .MAX_OUTPUTS (MAX_OUTPUTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_valid   (q_valid),
      .q_op      (q_op),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

>>> tb/tb.sv
// testbench for the two-layer perceptron inference block
`timescale 1ns / 100ps
module tb;
   import mlpfi_pkg::*;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   mlpfi_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   mlpfi_rsp_type rsp_data;
   logic          csr_wr_en;
   logic [1:0]    csr_index;
   logic [6:0]    csr_wdata;

   mlp_forward_inference u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // kind code with no operation behind it
   localparam logic [1:0] KIND_UNUSED = 2'd3;

   // predictor state
   int unsigned    sig_lut [1024];
   int             feat_mem [64];
   int             wt_hid [64][64];
   int             wt_out [16][64];
   int unsigned    hid_act [64];
   logic [6:0]     n_in_reg, n_hid_reg;
   logic [4:0]     n_out_reg;

   mlpfi_req_type  beat_q [$];
   mlpfi_rsp_type  act_expect_q [$];
   int             err_count;
   int             send_gap;
   int             recv_gap;
   int             hold_cnt;
   bit             held_once;

   localparam logic [29:0] EXP_TAB [15] = '{
      30'd1073479712, 30'd1073217664, 30'd1072693760, 30'd1071646719,
      30'd1069555701, 30'd1065385899, 30'd1057095000, 30'd1040706261,
      30'd1008687096, 30'd947573834,  30'd836230973,  30'd651257337,
      30'd395007542,  30'd145315154,  30'd19666268
   };

   always begin
      clock = 1'b1; #1;
      clock = 1'b0; #1;
   end

   function automatic int unsigned sigmoid_of(longint acc);
      longint q;
      q = acc >>> 12;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return sig_lut[int'((q + 32768) >> 6)];
   endfunction

   function automatic int clamp_cnt(int v, int hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic run_forward_pass();
      int ni, nh, no;
      longint acc;
      mlpfi_rsp_type r;
      ni = clamp_cnt(n_in_reg, 64);
      nh = clamp_cnt(n_hid_reg, 64);
      no = clamp_cnt(n_out_reg, RESULT_LIMIT);
      for (int h = 0; h < nh; h++) begin
         acc = 0;
         for (int k = 0; k < ni; k++) acc += longint'(wt_hid[h][k]) * feat_mem[k];
         hid_act[h] = sigmoid_of(acc);
      end
      for (int o = 0; o < no; o++) begin
         acc = 0;
         for (int k = 0; k < nh; k++) acc += longint'(wt_out[o][k]) * longint'(hid_act[k]);
         r.node_index = o[3:0];
         r.activation = 13'(sigmoid_of(acc));
         r.final_res  = (o == no - 1);
         act_expect_q.push_back(r);
      end
   endtask

   task automatic apply_beat(mlpfi_req_type b);
      case (b.kind)
         KIND_WR_HID: wt_hid[b.row][b.col] = b.value;
         KIND_WR_OUT: if (b.row < 16) wt_out[b.row][b.col] = b.value;
         KIND_FEATURE: begin
            feat_mem[b.col] = b.value;
            if (b.last) run_forward_pass();
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      err_count++;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) apply_beat(req_data);
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (beat_q.size() > 0) begin
               req_data  <= beat_q.pop_front();
               req_valid <= 1'b1;
               send_gap  <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      mlpfi_rsp_type w;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
         hold_cnt  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (act_expect_q.size() == 0) begin
               report_mismatch("unexpected beat node", rsp_data.node_index, -1);
            end else begin
               w = act_expect_q.pop_front();
               if (rsp_data.node_index != w.node_index)
                  report_mismatch("node_index", rsp_data.node_index, w.node_index);
               if (rsp_data.activation != w.activation)
                  report_mismatch("activation", rsp_data.activation, w.activation);
               if (rsp_data.final_res != w.final_res)
                  report_mismatch("final_res", rsp_data.final_res, w.final_res);
            end
         end
         // one long hold-off while beats are still pending so the input queue fills
         if (!held_once && rsp_valid && beat_q.size() >= 8) begin
            held_once <= 1'b1;
            hold_cnt  <= 4000;
            rsp_stall <= 1'b1;
         end else if (hold_cnt > 0) begin
            hold_cnt  <= hold_cnt - 1;
            rsp_stall <= 1'b1;
         end else if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (rsp_valid) recv_gap <= pick_gap();
         end
      end
   end

   task automatic push_beat(logic [1:0] k, int r, int c, int v, bit l);
      mlpfi_req_type b;
      b.kind = k; b.row = r[5:0]; b.col = c[5:0]; b.value = v[15:0]; b.last = l;
      beat_q.push_back(b);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (beat_q.size() != 0 || req_valid || act_expect_q.size() != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [6:0] val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_INPUTS:  n_in_reg  = val;
         CSR_HIDDEN:  n_hid_reg = val;
         default:     n_out_reg = val[4:0];
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_counts(int a, int b, int c);
      write_csr(CSR_INPUTS, a[6:0]);
      write_csr(CSR_HIDDEN, b[6:0]);
      write_csr(CSR_OUTPUTS, c[6:0]);
   endtask

   // well-formed vectors with some weight updates and noise mixed in
   task automatic queue_vectors(int nvec);
      int nf, r;
      for (int v = 0; v < nvec; v++) begin
         repeat ($urandom_range(0, 4)) begin
            r = $urandom_range(0, 9);
            if (r < 5) push_beat(KIND_WR_HID, $urandom_range(0, 63), $urandom_range(0, 63),
                                 $urandom, $urandom_range(0, 1));
            else if (r < 8) push_beat(KIND_WR_OUT, $urandom_range(0, 63),
                                      $urandom_range(0, 63), $urandom, $urandom_range(0, 1));
            else push_beat(KIND_UNUSED, $urandom, $urandom, $urandom, $urandom_range(0, 1));
         end
         nf = $urandom_range(1, 6);
         for (int f = 0; f < nf; f++)
            push_beat(KIND_FEATURE, $urandom, $urandom_range(0, 63), $urandom, f == nf - 1);
      end
   endtask

   initial begin
      longint unsigned e, den, num;
      int c, t;
      for (int i = 0; i < 1024; i++) begin
         c = -32768 + ((2 * i + 1) * 65536) / 2048;
         t = (c < 0 ? -c : c) & 32'h7fff;
         e = 64'd1073741824;
         for (int k = 0; k < 15; k++)
            if (t[k]) e = (e * EXP_TAB[k] + 64'd536870912) >> 30;
         den = 64'd1073741824 + e;
         num = (c >= 0) ? 64'd1073741824 : e;
         sig_lut[i] = int'((64'd4096 * num + den / 2) / den);
      end
      err_count = 0; held_once = 0;
      n_in_reg = RESET_INPUTS; n_hid_reg = RESET_HIDDEN; n_out_reg = RESET_OUTPUTS;
      req_valid = 1'b0; req_data = '0; rsp_stall = 1'b0;
      csr_wr_en = 1'b0; csr_index = CSR_INPUTS; csr_wdata = '0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // fill every store entry that the passes below read:
      // first row and column in full, plus the block used by the reset counts
      for (int k = 0; k < 64; k++) push_beat(KIND_WR_HID, 0, k, $urandom, 1'b0);
      for (int r = 1; r < 64; r++) push_beat(KIND_WR_HID, r, 0, $urandom, 1'b0);
      for (int r = 1; r < 9; r++)
         for (int k = 1; k < 12; k++) push_beat(KIND_WR_HID, r, k, $urandom, 1'b0);
      for (int k = 0; k < 64; k++) push_beat(KIND_WR_OUT, 0, k, $urandom, 1'b0);
      for (int r = 1; r < 16; r++) push_beat(KIND_WR_OUT, r, 0, $urandom, 1'b0);
      for (int r = 1; r < 4; r++)
         for (int k = 1; k < 9; k++) push_beat(KIND_WR_OUT, r, k, $urandom, 1'b0);
      for (int k = 0; k < 64; k++) push_beat(KIND_FEATURE, 0, k, $urandom, 1'b0);

      // directed: extremes, ignored writes, last on a weight write, kind 3
      push_beat(KIND_WR_HID, 0, 0, 32767, 1'b1);
      push_beat(KIND_WR_HID, 63, 63, -32768, 1'b0);
      push_beat(KIND_WR_OUT, 0, 0, -32768, 1'b0);
      push_beat(KIND_WR_OUT, 15, 63, 32767, 1'b1);
      push_beat(KIND_WR_OUT, 20, 5, 1234, 1'b0);
      push_beat(KIND_WR_OUT, 63, 63, -1, 1'b1);
      push_beat(KIND_UNUSED, 63, 63, -1, 1'b1);
      push_beat(KIND_FEATURE, 63, 63, 32767, 1'b0);
      push_beat(KIND_FEATURE, 0, 1, 32767, 1'b0);
      push_beat(KIND_FEATURE, 0, 0, -32768, 1'b1);
      push_beat(KIND_FEATURE, 0, 0, 32767, 1'b1);
      push_beat(KIND_FEATURE, 0, 5, 0, 1'b1);
      wait_idle();

      // counts above their maximum
      set_counts(127, 1, 31);
      queue_vectors(2);
      wait_idle();
      set_counts(1, 127, 1);
      queue_vectors(1);
      wait_idle();
      // counts of zero
      set_counts(0, 0, 0);
      queue_vectors(1);
      wait_idle();
      set_counts(12, 9, 4);
      queue_vectors(5);
      wait_idle();
      set_counts($urandom_range(1, 12), $urandom_range(1, 9), $urandom_range(1, 4));
      queue_vectors(2);
      wait_idle();

      if (err_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #6000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> files.f
rtl/core/mlpfi_pkg.sv
rtl/core/mlpfi_front.sv
rtl/core/mlpfi_sigmoid.sv
rtl/core/mlpfi_back.sv
rtl/core/mlp_forward_inference.sv
tb/tb.sv
